// ===== design/cars_pkg.sv =====
`timescale 1ns / 1ps

package cars_pkg;

    localparam int ADDR_BITS = 17;

    typedef enum logic [4:0] {
        OP_ADC     = 5'd0,
        OP_SBC     = 5'd1,
        OP_CMP     = 5'd2,
        OP_CPX     = 5'd3,
        OP_CPY     = 5'd4,
        OP_BIT     = 5'd5,
        OP_LDA     = 5'd6,
        OP_LDX     = 5'd7,
        OP_LDY     = 5'd8,
        OP_LSR_A   = 5'd9,
        OP_ASL_A   = 5'd10,
        OP_ROR_A   = 5'd11,
        OP_ROL_A   = 5'd12,
        OP_ASL_MEM = 5'd13,
        OP_ROR_MEM = 5'd14,
        OP_ROL_MEM = 5'd15,
        OP_DEX     = 5'd16,
        OP_DEY     = 5'd17,
        OP_INX     = 5'd18,
        OP_INY     = 5'd19
    } t_op;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic       n;
        logic       z;
        logic       c;
        logic       v;
    } t_state;

    typedef struct packed {
        logic [4:0]           req_type;
        logic [7:0]           operand;
        logic [ADDR_BITS-1:0] mem_address;
    } t_req;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           data;
    } t_wb;

endpackage

// ===== design/cars_if.sv =====
`timescale 1ns / 1ps

interface cars_req_if;
    import cars_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [4:0]           req_type;
    logic [7:0]           operand;
    logic [ADDR_BITS-1:0] mem_address;

    modport source (output valid, req_type, operand, mem_address, input ready);
    modport sink   (input valid, req_type, operand, mem_address, output ready);
endinterface

interface cars_rsp_if;
    import cars_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [7:0]           acc_out;
    logic [7:0]           x_out;
    logic [7:0]           y_out;
    logic                 flag_neg;
    logic                 flag_zero;
    logic                 flag_carry;
    logic                 flag_ovf;
    logic                 mem_write_enable;
    logic [ADDR_BITS-1:0] mem_write_address;
    logic [7:0]           mem_write_data;

    modport source (
        output valid, acc_out, x_out, y_out, flag_neg, flag_zero, flag_carry, flag_ovf,
               mem_write_enable, mem_write_address, mem_write_data,
        input  ready
    );
    modport sink (
        input  valid, acc_out, x_out, y_out, flag_neg, flag_zero, flag_carry, flag_ovf,
               mem_write_enable, mem_write_address, mem_write_data,
        output ready
    );
endinterface

// ===== design/cars_alu.sv =====
`timescale 1ns / 1ps

module cars_alu (
    input  cars_pkg::t_state i_st,
    input  cars_pkg::t_req   i_req,
    output cars_pkg::t_state o_st,
    output cars_pkg::t_wb    o_wb
);
    import cars_pkg::*;

    t_op        op;
    logic [7:0] m;
    logic [7:0] add_m;
    logic [8:0] sum;
    logic [7:0] cmp_reg;
    logic [8:0] diff;
    logic [7:0] res;
    logic       upd_nz;

    assign op    = t_op'(i_req.req_type);
    assign m     = i_req.operand;
    // SBC is ADC of the inverted operand, carry acts as inverted borrow
    assign add_m = (op == OP_SBC) ? ~m : m;
    assign sum   = {1'b0, i_st.acc} + {1'b0, add_m} + {8'd0, i_st.c};

    always_comb begin
        unique case (op)
            OP_CPX:  cmp_reg = i_st.x;
            OP_CPY:  cmp_reg = i_st.y;
            default: cmp_reg = i_st.acc;
        endcase
    end

    assign diff = {1'b0, cmp_reg} + {1'b0, ~m} + 9'd1;

    always_comb begin
        o_st    = i_st;
        o_wb    = '0;
        res     = '0;
        upd_nz  = 1'b0;
        unique case (op)
            OP_ADC, OP_SBC: begin
                res    = sum[7:0];
                o_st.acc = sum[7:0];
                o_st.c = sum[8];
                o_st.v = (i_st.acc[7] ^ sum[7]) & (add_m[7] ^ sum[7]);
                upd_nz = 1'b1;
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                res    = diff[7:0];
                o_st.c = diff[8];
                upd_nz = 1'b1;
            end
            OP_BIT: begin
                o_st.z = ((i_st.acc & m) == 8'd0);
                o_st.n = m[7];
                o_st.v = m[6];
            end
            OP_LDA: begin
                res = m; o_st.acc = m; upd_nz = 1'b1;
            end
            OP_LDX: begin
                res = m; o_st.x = m; upd_nz = 1'b1;
            end
            OP_LDY: begin
                res = m; o_st.y = m; upd_nz = 1'b1;
            end
            OP_LSR_A: begin
                res = {1'b0, i_st.acc[7:1]}; o_st.c = i_st.acc[0];
                o_st.acc = res; upd_nz = 1'b1;
            end
            OP_ASL_A: begin
                res = {i_st.acc[6:0], 1'b0}; o_st.c = i_st.acc[7];
                o_st.acc = res; upd_nz = 1'b1;
            end
            OP_ROR_A: begin
                res = {i_st.c, i_st.acc[7:1]}; o_st.c = i_st.acc[0];
                o_st.acc = res; upd_nz = 1'b1;
            end
            OP_ROL_A: begin
                res = {i_st.acc[6:0], i_st.c}; o_st.c = i_st.acc[7];
                o_st.acc = res; upd_nz = 1'b1;
            end
            OP_ASL_MEM: begin
                res = {m[6:0], 1'b0}; o_st.c = m[7]; upd_nz = 1'b1;
                o_wb = '{we: 1'b1, addr: i_req.mem_address, data: res};
            end
            OP_ROR_MEM: begin
                res = {i_st.c, m[7:1]}; o_st.c = m[0]; upd_nz = 1'b1;
                o_wb = '{we: 1'b1, addr: i_req.mem_address, data: res};
            end
            OP_ROL_MEM: begin
                res = {m[6:0], i_st.c}; o_st.c = m[7]; upd_nz = 1'b1;
                o_wb = '{we: 1'b1, addr: i_req.mem_address, data: res};
            end
            OP_DEX: begin
                res = i_st.x - 8'd1; o_st.x = res; upd_nz = 1'b1;
            end
            OP_DEY: begin
                res = i_st.y - 8'd1; o_st.y = res; upd_nz = 1'b1;
            end
            OP_INX: begin
                res = i_st.x + 8'd1; o_st.x = res; upd_nz = 1'b1;
            end
            OP_INY: begin
                res = i_st.y + 8'd1; o_st.y = res; upd_nz = 1'b1;
            end
            // unused codes leave everything as it is
            default: begin
                upd_nz = 1'b0;
            end
        endcase
        if (upd_nz) begin
            o_st.n = res[7];
            o_st.z = (res == 8'd0);
        end
    end

endmodule

// ===== design/cpu_alu_register_step.sv =====
`timescale 1ns / 1ps
// 8-bit binary-mode ALU with accumulator, X, Y and N/Z/C/V flags.
// Request channel i_req: req_type selects the operation, operand is the
// immediate or the byte already read from memory, mem_address is the target
// of a memory shift or rotate.
// Response channel o_rsp: one transaction per request, carrying A, X, Y and
// the flags after the operation, plus a write-back (enable, address, data)
// for memory shifts and rotates; address and data are zero otherwise.
// A request accepted at i_req lands in the input register, passes through the
// ALU and is loaded into the response register that drives o_rsp.
// Throughput: one request per cycle while the response side is not stalled; the
// architectural state updates in the same cycle the response register loads, so
// each operation sees the state left by the previous one through a single ALU pass.
// Reset clears A, X, Y, all flags and both stage valids.
// When the receiver stalls, the response holds, the input register fills,
// and then i_req.ready drops until o_rsp.ready returns.
module cpu_alu_register_step (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cars_req_if.sink   i_req,
    cars_rsp_if.source o_rsp
);
    import cars_pkg::*;

    logic   r_in_valid;
    t_req   r_req;
    t_state r_state;
    logic   r_out_valid;
    t_state r_out_st;
    t_wb    r_out_wb;

    t_state n_state;
    t_wb    n_wb;
    logic   advance;

    cars_alu u_alu (
        .i_st  (r_state),
        .i_req (r_req),
        .o_st  (n_state),
        .o_wb  (n_wb)
    );

    assign advance     = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_req <= '{req_type: i_req.req_type, operand: i_req.operand,
                       mem_address: i_req.mem_address};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
        if (advance && r_in_valid) begin
            r_out_st <= n_state;
            r_out_wb <= n_wb;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.acc_out           = r_out_st.acc;
    assign o_rsp.x_out             = r_out_st.x;
    assign o_rsp.y_out             = r_out_st.y;
    assign o_rsp.flag_neg          = r_out_st.n;
    assign o_rsp.flag_zero         = r_out_st.z;
    assign o_rsp.flag_carry        = r_out_st.c;
    assign o_rsp.flag_ovf          = r_out_st.v;
    assign o_rsp.mem_write_enable  = r_out_wb.we;
    assign o_rsp.mem_write_address = r_out_wb.addr;
    assign o_rsp.mem_write_data    = r_out_wb.data;

`ifndef SYNTHESIS
    // a pending response always mirrors the architectural state
    a_rsp_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_st == r_state))
        else $error("response differs from register state");

    // a held request is not dropped while the output stalls
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_req)))
        else $error("stalled request lost");

    // state changes only when a request moves into the response register
    a_state_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_valid && advance) |=> $stable(r_state))
        else $error("state changed without a request");

    // write-back fields are clean when no write is requested
    a_wb_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_wb.we) |-> (r_out_wb.addr == '0 && r_out_wb.data == '0))
        else $error("write-back fields set without enable");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import cars_pkg::*;

    typedef struct packed {
        logic [7:0]           acc;
        logic [7:0]           x;
        logic [7:0]           y;
        logic                 n;
        logic                 z;
        logic                 c;
        logic                 v;
        logic                 we;
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           data;
    } t_alu_result;

    class alu_scoreboard;
        t_state      regs;
        t_alu_result expected_q[$];
        int          errors;
        int          mismatches;

        function new();
            regs       = '0;
            errors     = 0;
            mismatches = 0;
        endfunction

        function void set_nz(logic [7:0] v);
            regs.z = (v == 8'h00);
            regs.n = v[7];
        endfunction

        function void add_with_carry(logic [7:0] m);
            logic [8:0] sum;
            sum    = {1'b0, regs.acc} + {1'b0, m} + {8'h00, regs.c};
            regs.v = (((regs.acc ^ sum[7:0]) & (m ^ sum[7:0]) & 8'h80) != 8'h00);
            regs.c = sum[8];
            regs.acc = sum[7:0];
            set_nz(regs.acc);
        endfunction

        function void compare_with(logic [7:0] r, logic [7:0] m);
            logic [8:0] diff;
            diff   = {1'b0, r} + {1'b0, ~m} + 9'd1;
            regs.c = diff[8];
            set_nz(diff[7:0]);
        endfunction

        function logic [7:0] shift_left(logic [7:0] v, logic in_bit);
            logic [7:0] r;
            regs.c = v[7];
            r      = {v[6:0], in_bit};
            set_nz(r);
            return r;
        endfunction

        function logic [7:0] shift_right(logic [7:0] v, logic in_bit);
            logic [7:0] r;
            regs.c = v[0];
            r      = {in_bit, v[7:1]};
            set_nz(r);
            return r;
        endfunction

        // Apply one operation to the register copy and queue the response it yields.
        function void note_request(logic [4:0] op, logic [7:0] m,
                                   logic [ADDR_BITS-1:0] addr);
            t_alu_result e;
            e = '0;
            unique case (op)
                OP_ADC:     add_with_carry(m);
                OP_SBC:     add_with_carry(~m);
                OP_CMP:     compare_with(regs.acc, m);
                OP_CPX:     compare_with(regs.x, m);
                OP_CPY:     compare_with(regs.y, m);
                OP_BIT: begin
                    regs.z = ((regs.acc & m) == 8'h00);
                    regs.n = m[7];
                    regs.v = m[6];
                end
                OP_LDA: begin
                    regs.acc = m;
                    set_nz(m);
                end
                OP_LDX: begin
                    regs.x = m;
                    set_nz(m);
                end
                OP_LDY: begin
                    regs.y = m;
                    set_nz(m);
                end
                OP_LSR_A:   regs.acc = shift_right(regs.acc, 1'b0);
                OP_ASL_A:   regs.acc = shift_left(regs.acc, 1'b0);
                OP_ROR_A:   regs.acc = shift_right(regs.acc, regs.c);
                OP_ROL_A:   regs.acc = shift_left(regs.acc, regs.c);
                OP_ASL_MEM: begin
                    e.we   = 1'b1;
                    e.data = shift_left(m, 1'b0);
                end
                OP_ROR_MEM: begin
                    e.we   = 1'b1;
                    e.data = shift_right(m, regs.c);
                end
                OP_ROL_MEM: begin
                    e.we   = 1'b1;
                    e.data = shift_left(m, regs.c);
                end
                OP_DEX: begin
                    regs.x = regs.x - 8'd1;
                    set_nz(regs.x);
                end
                OP_DEY: begin
                    regs.y = regs.y - 8'd1;
                    set_nz(regs.y);
                end
                OP_INX: begin
                    regs.x = regs.x + 8'd1;
                    set_nz(regs.x);
                end
                OP_INY: begin
                    regs.y = regs.y + 8'd1;
                    set_nz(regs.y);
                end
                default: ;
            endcase
            e.acc  = regs.acc;
            e.x    = regs.x;
            e.y    = regs.y;
            e.n    = regs.n;
            e.z    = regs.z;
            e.c    = regs.c;
            e.v    = regs.v;
            e.addr = e.we ? addr : '0;
            expected_q.push_back(e);
        endfunction

        function void check_response(t_alu_result got);
            t_alu_result e;
            if (expected_q.size() == 0) begin
                errors++;
                if (mismatches < 10)
                    $display("[%0t] response with nothing expected: %p", $realtime, got);
                mismatches++;
            end else begin
                e = expected_q.pop_front();
                if (got.acc !== e.acc || got.x !== e.x || got.y !== e.y ||
                    got.n !== e.n || got.z !== e.z || got.c !== e.c || got.v !== e.v ||
                    got.we !== e.we || got.addr !== e.addr || got.data !== e.data) begin
                    errors++;
                    if (mismatches < 10) begin
                        $display("[%0t] exp a=%h x=%h y=%h nzcv=%b%b%b%b we=%b addr=%h d=%h",
                                 $realtime, e.acc, e.x, e.y, e.n, e.z, e.c, e.v,
                                 e.we, e.addr, e.data);
                        $display("[%0t] got a=%h x=%h y=%h nzcv=%b%b%b%b we=%b addr=%h d=%h",
                                 $realtime, got.acc, got.x, got.y, got.n, got.z, got.c,
                                 got.v, got.we, got.addr, got.data);
                    end
                    mismatches++;
                end
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   bursty = 1'b1;

    alu_scoreboard sb = new();

    cars_req_if req_if ();
    cars_rsp_if rsp_if ();

    cpu_alu_register_step dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    // Record every transaction on both channels as it is accepted.
    always @(posedge clk) begin
        if (rst_n && req_if.valid && req_if.ready)
            sb.note_request(req_if.req_type, req_if.operand, req_if.mem_address);
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response({rsp_if.acc_out, rsp_if.x_out, rsp_if.y_out,
                               rsp_if.flag_neg, rsp_if.flag_zero, rsp_if.flag_carry,
                               rsp_if.flag_ovf, rsp_if.mem_write_enable,
                               rsp_if.mem_write_address, rsp_if.mem_write_data});
    end

    // Response side: random bursts of ready and stall while bursty is set, else ready.
    initial begin
        int span;
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            span = $urandom_range(1, 16);
            if (bursty && $urandom_range(0, 2) == 0)
                rsp_if.ready <= 1'b0;
            else
                rsp_if.ready <= 1'b1;
            repeat (span) @(posedge clk);
        end
    end

    task automatic send_request(logic [4:0] op, logic [7:0] m, logic [ADDR_BITS-1:0] addr);
        if (bursty && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= op;
        req_if.operand     <= m;
        req_if.mem_address <= addr;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    // Hold off new requests until every response is back.
    task automatic drain_responses();
        req_if.valid <= 1'b0;
        // let the monitor note the last accepted transaction first
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    initial begin
        logic [4:0]           op;
        logic [ADDR_BITS-1:0] addr;
        int                   guard;

        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.req_type    <= '0;
        req_if.operand     <= '0;
        req_if.mem_address <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every operation, flag corner cases.
        send_request(OP_LDA, 8'h00, '0);
        send_request(OP_LDA, 8'h80, '0);
        send_request(OP_ADC, 8'h80, '0);        // 0x80 + 0x80: carry and overflow
        send_request(OP_ADC, 8'h7f, '0);        // carry in pushes over into bit 7
        send_request(OP_SBC, 8'h01, '0);
        send_request(OP_SBC, 8'hff, '0);        // borrow through inverted carry
        send_request(OP_LDX, 8'hff, '0);
        send_request(OP_INX, 8'h00, '0);        // wrap to zero
        send_request(OP_DEX, 8'h00, '0);        // wrap to 0xff
        send_request(OP_LDY, 8'h00, '0);
        send_request(OP_DEY, 8'h00, '0);
        send_request(OP_INY, 8'h00, '0);
        send_request(OP_CMP, 8'h80, '0);
        send_request(OP_CPX, 8'hff, '0);
        send_request(OP_CPY, 8'h01, '0);
        send_request(OP_BIT, 8'hc0, '0);
        send_request(OP_BIT, 8'h3f, '0);
        send_request(OP_LDA, 8'h81, '0);
        send_request(OP_LSR_A, 8'h00, '0);
        send_request(OP_ASL_A, 8'h00, '0);
        send_request(OP_ROR_A, 8'h00, '0);
        send_request(OP_ROL_A, 8'h00, '0);
        send_request(OP_ASL_MEM, 8'h81, {ADDR_BITS{1'b1}});
        send_request(OP_ROR_MEM, 8'h01, '0);
        send_request(OP_ROL_MEM, 8'hff, 17'h15555);
        send_request(5'd20, 8'hff, {ADDR_BITS{1'b1}});
        send_request(5'd31, 8'h00, '0);
        drain_responses();

        for (int i = 0; i < 950; i++) begin
            if (i == 800)
                bursty = 1'b0;
            if (i == 400)
                drain_responses();
            if ($urandom_range(0, 99) < 6)
                op = 5'($urandom_range(20, 31));
            else
                op = 5'($urandom_range(0, 19));
            case ($urandom_range(0, 7))
                0:       addr = '0;
                1:       addr = {ADDR_BITS{1'b1}};
                default: addr = ADDR_BITS'($urandom_range(0, (1 << ADDR_BITS) - 1));
            endcase
            send_request(op, 8'($urandom_range(0, 255)), addr);
        end
        req_if.valid <= 1'b0;
        @(posedge clk);

        guard = 0;
        while (sb.outstanding() != 0 && guard < 10000) begin
            @(posedge clk);
            guard++;
        end
        if (sb.outstanding() != 0) begin
            $display("%0d responses never arrived", sb.outstanding());
            sb.errors++;
        end
        repeat (10) @(posedge clk);

        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/cars_pkg.sv
design/cars_if.sv
design/cars_alu.sv
design/cpu_alu_register_step.sv
verif/tb_top.sv
